[hw/rtl/sgp_pkg.sv]
package sgp_pkg;

  // Bit slots shifted out of the pad per poll (12..16)
  localparam int unsigned SERIAL_BITS_DEF = 16;

  localparam int unsigned TICK_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BTN_W     = 8;
  localparam int unsigned AXIS_W    = 2;

  typedef logic [TICK_W-1:0]    tick_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [BTN_W-1:0]     btn_t;
  typedef logic signed [AXIS_W-1:0] axis_t;

  // Register indexes on the config port
  localparam cfg_idx_t CFG_LATCH_HIGH  = 2'd0;
  localparam cfg_idx_t CFG_SETTLE      = 2'd1;
  localparam cfg_idx_t CFG_HALF_PERIOD = 2'd2;

  localparam tick_t LATCH_HIGH_RST  = 16'd12;
  localparam tick_t SETTLE_RST      = 16'd6;
  localparam tick_t HALF_PERIOD_RST = 16'd6;

  localparam axis_t AXIS_NEG  = 2'sb11;
  localparam axis_t AXIS_POS  = 2'sb01;
  localparam axis_t AXIS_ZERO = 2'sb00;

endpackage

[hw/rtl/sgp_if.sv]
interface sgp_in_if;
  import sgp_pkg::*;
  logic valid;
  logic ready;
  logic start_poll;
  logic data_level;

  modport source (output valid, output start_poll, output data_level, input ready);
  modport sink   (input valid, input start_poll, input data_level, output ready);
endinterface

interface sgp_out_if;
  import sgp_pkg::*;
  logic  valid;
  logic  ready;
  logic  latch_level;
  logic  clock_level;
  logic  busy_res;
  logic  poll_done;
  btn_t  button_bits;
  axis_t axis_vertical;
  axis_t axis_horizontal;

  modport source (output valid, output latch_level, output clock_level, output busy_res,
                  output poll_done, output button_bits, output axis_vertical,
                  output axis_horizontal, input ready);
  modport sink   (input valid, input latch_level, input clock_level, input busy_res,
                  input poll_done, input button_bits, input axis_vertical,
                  input axis_horizontal, output ready);
endinterface

interface sgp_cfg_if;
  import sgp_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  tick_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/serial_gamepad_poller.sv]
// Channel   Dir  Handshake       Word
// in_ch     in   valid/ready     start_poll, data_level (one timing tick)
// out_ch    out  valid/ready     latch/clock levels, busy, done, buttons, axes
// cfg_ch    in   valid/ready     index, data (ready always high)
//
// One tick word is taken per cycle unless in_ch.ready is held low; its result word appears in the next cycle.
// The sequencer state and the result register update together on accept.
// in_ch.ready is low only while a result word waits and out_ch.ready is low.
// Synchronous active-low reset: idle, registers at 12/6/6, results zero.
module serial_gamepad_poller #(
  parameter int unsigned SERIAL_BITS = sgp_pkg::SERIAL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sgp_in_if.sink       in_ch,
  sgp_out_if.source    out_ch,
  sgp_cfg_if.sink      cfg_ch
);
  import sgp_pkg::*;

  localparam int unsigned IDX_W = $clog2(SERIAL_BITS);
  localparam int unsigned CNT_W = $clog2(SERIAL_BITS + 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LATCH, PH_SETTLE, PH_CLK_LOW, PH_CLK_HIGH
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  tick_t                  tick_r, tick_nxt;
  logic [CNT_W-1:0]       bit_idx_r, bit_idx_nxt;
  logic [SERIAL_BITS-1:0] shift_r, shift_nxt;
  btn_t                   buttons_r, buttons_nxt;
  axis_t                  axis_v_r, axis_v_nxt;
  axis_t                  axis_h_r, axis_h_nxt;
  logic                   done_r, done_nxt;
  logic                   out_valid_r;

  tick_t latch_high_r, settle_r, half_period_r;

  logic             accept;
  logic [CNT_W-1:0] idx_inc;
  logic             pressed;

  function automatic tick_t at_least_one(tick_t v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic axis_t axis_code(logic neg, logic pos);
    return neg ? AXIS_NEG : (pos ? AXIS_POS : AXIS_ZERO);
  endfunction

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign idx_inc = bit_idx_r + CNT_W'(1);
  assign pressed = !in_ch.data_level;

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    buttons_nxt = buttons_r;
    axis_v_nxt  = axis_v_r;
    axis_h_nxt  = axis_h_r;
    done_nxt    = 1'b0;
    case (phase_r)
      PH_LATCH: begin
        if (tick_r >= at_least_one(latch_high_r)) begin
          phase_nxt = PH_SETTLE;
          tick_nxt  = TICK_W'(1);
        end else begin
          tick_nxt = tick_r + TICK_W'(1);
        end
      end
      PH_SETTLE: begin
        if (tick_r >= at_least_one(settle_r)) begin
          if (pressed) begin
            shift_nxt = shift_r | (SERIAL_BITS'(1) << bit_idx_r[IDX_W-1:0]);
          end
          phase_nxt = PH_CLK_LOW;
          tick_nxt  = TICK_W'(1);
        end else begin
          tick_nxt = tick_r + TICK_W'(1);
        end
      end
      PH_CLK_LOW: begin
        if (tick_r >= at_least_one(half_period_r)) begin
          phase_nxt = PH_CLK_HIGH;
          tick_nxt  = TICK_W'(1);
        end else begin
          tick_nxt = tick_r + TICK_W'(1);
        end
      end
      PH_CLK_HIGH: begin
        if (tick_r >= at_least_one(half_period_r)) begin
          if (idx_inc >= CNT_W'(SERIAL_BITS)) begin
            // last slot done: publish, high nibble of the word is dropped
            buttons_nxt = {shift_r[11:8], shift_r[3:0]};
            axis_v_nxt  = axis_code(shift_r[4], shift_r[5]);
            axis_h_nxt  = axis_code(shift_r[6], shift_r[7]);
            done_nxt    = 1'b1;
            phase_nxt   = PH_IDLE;
            tick_nxt    = '0;
            bit_idx_nxt = '0;
          end else begin
            if (pressed) begin
              shift_nxt = shift_r | (SERIAL_BITS'(1) << idx_inc[IDX_W-1:0]);
            end
            bit_idx_nxt = idx_inc;
            phase_nxt   = PH_CLK_LOW;
            tick_nxt    = TICK_W'(1);
          end
        end else begin
          tick_nxt = tick_r + TICK_W'(1);
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (in_ch.start_poll) begin
          phase_nxt   = PH_LATCH;
          tick_nxt    = TICK_W'(1);
          bit_idx_nxt = '0;
          shift_nxt   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bit_idx_r   <= '0;
      shift_r     <= '0;
      buttons_r   <= '0;
      axis_v_r    <= AXIS_ZERO;
      axis_h_r    <= AXIS_ZERO;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        tick_r    <= tick_nxt;
        bit_idx_r <= bit_idx_nxt;
        shift_r   <= shift_nxt;
        buttons_r <= buttons_nxt;
        axis_v_r  <= axis_v_nxt;
        axis_h_r  <= axis_h_nxt;
        done_r    <= done_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_high_r  <= LATCH_HIGH_RST;
      settle_r      <= SETTLE_RST;
      half_period_r <= HALF_PERIOD_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_LATCH_HIGH:  latch_high_r  <= cfg_ch.data;
        CFG_SETTLE:      settle_r      <= cfg_ch.data;
        CFG_HALF_PERIOD: half_period_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // result word is read straight from the sequencer registers, which only move on accept
  assign out_ch.valid           = out_valid_r;
  assign out_ch.latch_level     = (phase_r == PH_LATCH);
  assign out_ch.clock_level     = (phase_r != PH_CLK_LOW);
  assign out_ch.busy_res        = (phase_r != PH_IDLE);
  assign out_ch.poll_done       = done_r;
  assign out_ch.button_bits     = buttons_r;
  assign out_ch.axis_vertical   = axis_v_r;
  assign out_ch.axis_horizontal = axis_h_r;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (phase_r == PH_IDLE))
    else $error("poll_done while sequencer busy");

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (bit_idx_r == '0))
    else $error("bit index not cleared in idle");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_idx_r < CNT_W'(SERIAL_BITS))
    else $error("bit index past last slot");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (phase_r == PH_IDLE) && in_ch.start_poll) |=> (phase_r == PH_LATCH))
    else $error("poll request not started");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> ($stable(phase_r) && $stable(tick_r)))
    else $error("sequencer moved while result stalled");
`endif

endmodule

[dv/sgp_checker.sv]
`timescale 1ns / 1ps
module sgp_checker #(
  parameter int unsigned SERIAL_BITS = sgp_pkg::SERIAL_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sgp_in_if    in_ch,
  sgp_out_if   out_ch,
  sgp_cfg_if   cfg_ch,
  output int   n_fail,
  output int   n_pending,
  output logic pad_idle
);
  import sgp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LATCH,
    ST_SETTLE,
    ST_CLK_LO,
    ST_CLK_HI
  } seq_state_e;

  typedef struct packed {
    logic  latch;
    logic  clock;
    logic  busy;
    logic  done;
    btn_t  buttons;
    axis_t vert;
    axis_t horiz;
  } pad_word_t;

  tick_t       latch_ticks;
  tick_t       settle_ticks;
  tick_t       half_ticks;
  seq_state_e  seq_state;
  tick_t       tick_ctr;
  logic [4:0]  slot;
  logic [15:0] rx_word;
  btn_t        held_buttons;
  axis_t       held_vert;
  axis_t       held_horiz;
  pad_word_t   pad_words_q[$];

  initial n_fail = 0;

  function automatic tick_t min_one(tick_t v);
    return (v == '0) ? tick_t'(1) : v;
  endfunction

  // up/left wins over down/right
  function automatic axis_t axis_of(logic neg, logic pos);
    if (neg) return AXIS_NEG;
    if (pos) return AXIS_POS;
    return AXIS_ZERO;
  endfunction

  // print is capped so a dead block cannot flood the log; every mismatch still counts
  task automatic report(string what, int unsigned got, int unsigned want);
    if (n_fail < 100) $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
    n_fail++;
  endtask

  task automatic clear_pad();
    seq_state    = ST_IDLE;
    tick_ctr     = '0;
    slot         = '0;
    rx_word      = '0;
    held_buttons = '0;
    held_vert    = AXIS_ZERO;
    held_horiz   = AXIS_ZERO;
    latch_ticks  = LATCH_HIGH_RST;
    settle_ticks = SETTLE_RST;
    half_ticks   = HALF_PERIOD_RST;
  endtask

  task automatic predict_tick(logic start, logic data);
    pad_word_t w;
    logic      done;
    done = 1'b0;
    case (seq_state)
      ST_LATCH: begin
        if (tick_ctr >= min_one(latch_ticks)) begin
          seq_state = ST_SETTLE;
          tick_ctr  = 16'd1;
        end else begin
          tick_ctr++;
        end
      end
      ST_SETTLE: begin
        if (tick_ctr >= min_one(settle_ticks)) begin
          if (!data) rx_word[slot[3:0]] = 1'b1;
          seq_state = ST_CLK_LO;
          tick_ctr  = 16'd1;
        end else begin
          tick_ctr++;
        end
      end
      ST_CLK_LO: begin
        if (tick_ctr >= min_one(half_ticks)) begin
          seq_state = ST_CLK_HI;
          tick_ctr  = 16'd1;
        end else begin
          tick_ctr++;
        end
      end
      ST_CLK_HI: begin
        if (tick_ctr >= min_one(half_ticks)) begin
          slot = slot + 5'd1;
          if (slot >= SERIAL_BITS) begin
            // serial bits 12..15 are dropped
            held_buttons = {rx_word[11:8], rx_word[3:0]};
            held_vert    = axis_of(rx_word[4], rx_word[5]);
            held_horiz   = axis_of(rx_word[6], rx_word[7]);
            done         = 1'b1;
            seq_state    = ST_IDLE;
            tick_ctr     = '0;
            slot         = '0;
          end else begin
            if (!data) rx_word[slot[3:0]] = 1'b1;
            seq_state = ST_CLK_LO;
            tick_ctr  = 16'd1;
          end
        end else begin
          tick_ctr++;
        end
      end
      default: begin
        seq_state = ST_IDLE;
        if (start) begin
          seq_state = ST_LATCH;
          tick_ctr  = 16'd1;
          slot      = '0;
          rx_word   = '0;
        end
      end
    endcase
    w.latch   = (seq_state == ST_LATCH);
    w.clock   = (seq_state != ST_CLK_LO);
    w.busy    = (seq_state != ST_IDLE);
    w.done    = done;
    w.buttons = held_buttons;
    w.vert    = held_vert;
    w.horiz   = held_horiz;
    pad_words_q.push_back(w);
  endtask

  task automatic check_word();
    pad_word_t w;
    if (pad_words_q.size() == 0) begin
      report("result word with nothing expected", 0, 0);
      return;
    end
    w = pad_words_q.pop_front();
    if (out_ch.latch_level !== w.latch) report("latch_level", out_ch.latch_level, w.latch);
    if (out_ch.clock_level !== w.clock) report("clock_level", out_ch.clock_level, w.clock);
    if (out_ch.busy_res !== w.busy) report("busy_res", out_ch.busy_res, w.busy);
    if (out_ch.poll_done !== w.done) report("poll_done", out_ch.poll_done, w.done);
    if (out_ch.button_bits !== w.buttons)
      report("button_bits", out_ch.button_bits, w.buttons);
    if (out_ch.axis_vertical !== w.vert)
      report("axis_vertical", $unsigned(out_ch.axis_vertical), $unsigned(w.vert));
    if (out_ch.axis_horizontal !== w.horiz)
      report("axis_horizontal", $unsigned(out_ch.axis_horizontal), $unsigned(w.horiz));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_pad();
      pad_words_q.delete();
    end else begin
      // a result word is registered after its tick, so pop before push
      if (out_ch.valid && out_ch.ready) check_word();
      if (in_ch.valid && in_ch.ready) predict_tick(in_ch.start_poll, in_ch.data_level);
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_LATCH_HIGH:  latch_ticks  = cfg_ch.data;
          CFG_SETTLE:      settle_ticks = cfg_ch.data;
          CFG_HALF_PERIOD: half_ticks   = cfg_ch.data;
          default: ;
        endcase
      end
    end
    n_pending <= pad_words_q.size();
    pad_idle  <= (seq_state == ST_IDLE);
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import sgp_pkg::*;

  localparam cfg_idx_t CFG_SPARE    = 2'd3;  // index with no register behind it
  localparam int       STALL_LIMIT  = 2000;
  localparam int       RANDOM_ITEMS = 150;
  localparam int       QUIET_ITEMS  = 50;

  logic clk;
  logic rst_n;

  sgp_in_if  in_ch();
  sgp_out_if out_ch();
  sgp_cfg_if cfg_ch();

  int   n_fail;
  int   n_pending;
  logic pad_idle;

  tick_t cur_latch;
  tick_t cur_settle;
  tick_t cur_half;
  int    gap_odds;
  int    hold_odds;
  bit    quiet;
  int    n_items;
  int    stall_ctr;

  serial_gamepad_poller u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sgp_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .pad_idle  (pad_idle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(50, 200)) @(posedge clk);
      else repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_ctr <= 0;
    end else if (stall_ctr >= STALL_LIMIT) begin
      $display("serial_gamepad_poller regression: fail");
      $finish;
    end else begin
      stall_ctr <= stall_ctr + 1;
    end
  end

  function automatic int span(tick_t v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  task automatic drain(bit need_idle);
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (n_pending != 0 || (need_idle && !pad_idle)) @(posedge clk);
  endtask

  task automatic send_tick(logic s, logic d);
    if (!quiet && hold_odds != 0 && $urandom_range(1, hold_odds) == 1) drain(1'b0);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.start_poll <= s;
    in_ch.data_level <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
  endtask

  task automatic write_reg(cfg_idx_t idx, tick_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_LATCH_HIGH:  cur_latch  = val;
      CFG_SETTLE:      cur_settle = val;
      CFG_HALF_PERIOD: cur_half   = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(tick_t lat, tick_t stl, tick_t hp);
    drain(1'b1);
    write_reg(CFG_LATCH_HIGH, lat);
    write_reg(CFG_SETTLE, stl);
    write_reg(CFG_HALF_PERIOD, hp);
  endtask

  // One full poll from idle. Pressed bits go out active low on the sample
  // ticks; every other tick carries a random data level and, while busy,
  // a random (ignored) request; the request on the done tick is req_at_done.
  task automatic run_poll(logic [15:0] pressed, logic req_at_done);
    int   lat;
    int   stl;
    int   hp;
    int   last;
    int   rel;
    logic s;
    logic d;
    lat  = span(cur_latch);
    stl  = span(cur_settle);
    hp   = span(cur_half);
    last = lat + stl + 2 * SERIAL_BITS_DEF * hp;
    for (int t = 0; t <= last; t++) begin
      s   = (t == 0) ? 1'b1 : (t == last) ? req_at_done : 1'($urandom_range(0, 1));
      d   = 1'($urandom_range(0, 1));
      rel = t - lat - stl;
      if (rel >= 0 && rel % (2 * hp) == 0 && rel / (2 * hp) < SERIAL_BITS_DEF)
        d = ~pressed[rel / (2 * hp)];
      send_tick(s, d);
    end
  endtask

  // random words, then quiet ticks until the pad is back at idle
  task automatic noise(int n);
    repeat (n) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    do begin
      send_tick(1'b0, 1'($urandom_range(0, 1)));
    end while (!pad_idle);
  endtask

  initial begin
    int base;
    in_ch.valid      <= 1'b0;
    in_ch.start_poll <= 1'b0;
    in_ch.data_level <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_LATCH_HIGH;
    cfg_ch.data      <= '0;
    rst_n            <= 1'b0;
    cur_latch  = LATCH_HIGH_RST;
    cur_settle = SETTLE_RST;
    cur_half   = HALF_PERIOD_RST;
    gap_odds   = 6;
    hold_odds  = 0;
    quiet      = 1'b0;
    n_items    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing, nothing pressed, then a few idle words
    run_poll(16'h0000, 1'b0);
    repeat (3) send_tick(1'b0, 1'($urandom_range(0, 1)));
    drain(1'b0);

    // zero counts behave as one
    set_timing(16'd0, 16'd0, 16'd0);
    run_poll(16'hFFFF, 1'b1);  // request on the done tick must be dropped
    run_poll(16'h0030, 1'b1);  // up and down together
    run_poll(16'h0020, 1'b0);  // down only
    run_poll(16'h00C0, 1'b1);  // left and right together
    run_poll(16'h0080, 1'b0);  // right only
    run_poll(16'h0F0F, 1'b0);  // buttons only
    run_poll(16'hF000, 1'b0);  // unused slots only
    drain(1'b1);
    write_reg(CFG_SPARE, 16'hFFFF);
    run_poll(16'h5A3C, 1'b0);
    noise(20);

    // longest counts loaded, no poll started under them
    gap_odds = 64;
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (20) send_tick(1'b0, 1'($urandom_range(0, 1)));
    set_timing(16'd1, 16'd2, 16'd1);
    run_poll(16'h8421, 1'b1);

    base      = n_items;
    hold_odds = 300;
    while (n_items - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 5) == 0)
          set_timing(LATCH_HIGH_RST, SETTLE_RST, HALF_PERIOD_RST);
        else
          set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                     16'($urandom_range(0, 2)));
      end
      case ($urandom_range(0, 3))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        2:       gap_odds = 8;
        default: gap_odds = 20;
      endcase
      case ($urandom_range(0, 9))
        0:       noise($urandom_range(1, 25));
        1:       repeat ($urandom_range(1, 6)) send_tick(1'b0, 1'($urandom_range(0, 1)));
        default: run_poll(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
      endcase
      quiet = (n_items - base) >= RANDOM_ITEMS - QUIET_ITEMS;
    end

    in_ch.valid <= 1'b0;
    while (n_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("serial_gamepad_poller regression: pass");
    end else begin
      $display("serial_gamepad_poller regression: fail");
    end
    $finish;
  end

endmodule
